### src/gnf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnf_pkg
// Shared types and constants of the gradient noise block.
// ----------------------------------------------------------------------------
package gnf_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int MAX_OCTAVES = 8;
	localparam int ACC_W       = 40;
	localparam int MUL_A_W     = 18;
	localparam int MUL_B_W     = 22;
	localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

	localparam logic [1:0] REG_DIMENSIONS = 2'd0;
	localparam logic [1:0] REG_FRACTAL    = 2'd1;
	localparam logic [1:0] REG_OCTAVES    = 2'd2;

	typedef struct packed {
		logic [1:0] dimensions;
		logic       fractal_enable;
		logic [3:0] octave_count;
	} cfg_t;

	typedef struct packed {
		logic       we;
		logic [7:0] waddr;
		logic [7:0] wdata;
		logic [7:0] raddr;
	} mem_req_t;

endpackage
`default_nettype wire

### src/gnf_hash_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnf_hash_mem
// Hash table of 256 bytes with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gnf_hash_mem (
	input  wire                 clk,
	input  gnf_pkg::mem_req_t   req,
	output logic [7:0]          rdata
);
	import gnf_pkg::*;

	logic [7:0] mem [256];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule
`default_nettype wire

### src/gnf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module gnf_mul (
	input  wire                                  clk,
	input  wire signed [gnf_pkg::MUL_A_W-1:0]    a,
	input  wire signed [gnf_pkg::MUL_B_W-1:0]    b,
	output logic signed [gnf_pkg::MUL_P_W-1:0]   prod
);
	import gnf_pkg::*;

	always_ff @(posedge clk) begin
		prod <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule
`default_nettype wire

### src/gnf_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnf_core
// Sequencer for fade, hashing, gradient interpolation and octave summing.
// ----------------------------------------------------------------------------
module gnf_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  gnf_pkg::cfg_t       cfg,
	input  wire                 start,
	input  wire                 req_type,
	input  wire [7:0]           table_index,
	input  wire [7:0]           table_value,
	input  wire [31:0]          coord_x,
	input  wire [31:0]          coord_y,
	input  wire [31:0]          coord_z,
	output logic                idle,
	output logic                res_valid,
	input  wire                 res_take,
	output logic signed [17:0]  res_value
);
	import gnf_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FADE  = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_LERP  = 3'd3;
	localparam logic [2:0] ST_ACCUM = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam logic [37:0] TEN_S2 = 38'd10 << (2 * FRAC_BITS);
	localparam logic [23:0] FADE_ONE = 24'd1 << FRAC_BITS;

	logic [2:0] state_q;
	logic [31:0] cx_q, cy_q, cz_q;
	logic [1:0] ax_q, ph_q;
	logic [3:0] hs_q, oct_q;
	logic [2:0] lk_q;
	logic [19:0] p_q;
	logic [16:0] fd_q [3];
	logic [7:0] a_q, b_q, aa_q, ab_q, ba_q, bb_q;
	logic signed [17:0] g_q [8];
	logic signed [17:0] lv_q [7];
	logic signed [ACC_W-1:0] acc_q;
	logic signed [17:0] noise_q;

	mem_req_t mreq;
	logic [7:0] rdata;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;

	logic [1:0] dims;
	logic [3:0] oct_eff;
	logic [15:0] t_cur;
	logic [37:0] p_full;
	logic [16:0] lf;
	logic signed [17:0] lo, hi;
	logic signed [18:0] diff;
	logic signed [24:0] lsum;
	logic [2:0] corner;
	logic [7:0] cbase;
	logic signed [17:0] noise_sel;
	logic signed [ACC_W-1:0] fr;
	logic [3:0] hs_g;

	function automatic logic signed [17:0] grad(input logic [7:0] hash, input logic [2:0] c,
			input logic [15:0] xf, input logic [15:0] yf, input logic [15:0] zf);
		logic [3:0] h;
		logic signed [16:0] x, y, z, u, v;
		logic signed [17:0] su, sv;
		h = hash[3:0];
		x = c[0] ? $signed({1'b0, xf} - 17'd65536) : $signed({1'b0, xf});
		y = c[1] ? $signed({1'b0, yf} - 17'd65536) : $signed({1'b0, yf});
		z = c[2] ? $signed({1'b0, zf} - 17'd65536) : $signed({1'b0, zf});
		u = (h < 4'd8) ? x : y;
		v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
		su = h[0] ? -18'(u) : 18'(u);
		sv = h[1] ? -18'(v) : 18'(v);
		return su + sv;
	endfunction

	gnf_hash_mem u_mem (.clk(clk), .req(mreq), .rdata(rdata));
	gnf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

	assign dims = (cfg.dimensions == 2'd0) ? 2'd1 : cfg.dimensions;
	assign oct_eff = (cfg.octave_count > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : cfg.octave_count;
	assign idle = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		case (ax_q)
			2'd0:    t_cur = cx_q[15:0];
			2'd1:    t_cur = cy_q[15:0];
			default: t_cur = cz_q[15:0];
		endcase
	end

	assign p_full = 38'({prod[31:0], 2'b00}) + 38'({prod[31:0], 1'b0}) + TEN_S2
		- (38'(t_cur) * 38'd15 << FRAC_BITS);

	always_comb begin
		case (lk_q)
			3'd0:    begin lf = fd_q[0]; lo = g_q[0];  hi = g_q[1];  end
			3'd1:    begin lf = fd_q[0]; lo = g_q[2];  hi = g_q[3];  end
			3'd2:    begin lf = fd_q[1]; lo = lv_q[0]; hi = lv_q[1]; end
			3'd3:    begin lf = fd_q[0]; lo = g_q[4];  hi = g_q[5];  end
			3'd4:    begin lf = fd_q[0]; lo = g_q[6];  hi = g_q[7];  end
			3'd5:    begin lf = fd_q[1]; lo = lv_q[3]; hi = lv_q[4]; end
			default: begin lf = fd_q[2]; lo = lv_q[2]; hi = lv_q[5]; end
		endcase
	end

	assign diff = 19'(hi) - 19'(lo);
	assign lsum = 25'(lo) + 25'(prod >>> FRAC_BITS);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_FADE) begin
			case (ph_q)
				2'd0: begin
					mul_a = MUL_A_W'(t_cur);
					mul_b = MUL_B_W'(t_cur);
				end
				2'd1: begin
					mul_a = MUL_A_W'(prod[31:16]);
					mul_b = MUL_B_W'(t_cur);
				end
				default: begin
					mul_a = MUL_A_W'(prod[31:16]);
					mul_b = MUL_B_W'(p_q);
				end
			endcase
		end else if (state_q == ST_LERP) begin
			mul_a = MUL_A_W'(lf);
			mul_b = MUL_B_W'(diff);
		end
	end

	assign corner = 3'(hs_q - 4'd6);
	assign hs_g = hs_q - 4'd7;

	always_comb begin
		case (corner[1:0])
			2'd0:    cbase = aa_q;
			2'd1:    cbase = ba_q;
			2'd2:    cbase = ab_q;
			default: cbase = bb_q;
		endcase
	end

	always_comb begin
		mreq.we = start && !req_type && idle;
		mreq.waddr = table_index;
		mreq.wdata = table_value;
		case (hs_q)
			4'd0:    mreq.raddr = cx_q[23:16];
			4'd1:    mreq.raddr = cx_q[23:16] + 8'd1;
			4'd2:    mreq.raddr = a_q;
			4'd3:    mreq.raddr = a_q + 8'd1;
			4'd4:    mreq.raddr = b_q;
			4'd5:    mreq.raddr = b_q + 8'd1;
			default: mreq.raddr = cbase + 8'(corner[2]);
		endcase
	end

	always_comb begin
		case (dims)
			2'd1:    noise_sel = lv_q[0];
			2'd2:    noise_sel = lv_q[2];
			default: noise_sel = lv_q[6];
		endcase
	end

	assign fr = (acc_q >>> 17) + ACC_W'(32768);

	always_comb begin
		if (!cfg.fractal_enable) begin
			res_value = noise_q;
		end else if (fr > ACC_W'(131071)) begin
			res_value = 18'sd131071;
		end else if (fr < -ACC_W'(131072)) begin
			res_value = -18'sd131072;
		end else begin
			res_value = fr[17:0];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cx_q <= coord_x;
				cy_q <= (dims < 2'd2) ? 32'd0 : coord_y;
				cz_q <= (dims < 2'd3) ? 32'd0 : coord_z;
				acc_q <= '0;
			end
			ST_FADE: begin
				if (ph_q == 2'd1) begin
					p_q <= p_full[35:16];
				end
				if (ph_q == 2'd3) begin
					fd_q[ax_q] <= (prod[39:16] > FADE_ONE) ? 17'(FADE_ONE) : prod[32:16];
				end
			end
			ST_HASH: begin
				case (hs_q)
					4'd1:    a_q <= rdata + cy_q[23:16];
					4'd2:    b_q <= rdata + cy_q[23:16];
					4'd3:    aa_q <= rdata + cz_q[23:16];
					4'd4:    ab_q <= rdata + cz_q[23:16];
					4'd5:    ba_q <= rdata + cz_q[23:16];
					4'd6:    bb_q <= rdata + cz_q[23:16];
					default: begin
						if (hs_q >= 4'd7) begin
							g_q[hs_g[2:0]] <= grad(rdata, hs_g[2:0], cx_q[15:0],
								cy_q[15:0], cz_q[15:0]);
						end
					end
				endcase
			end
			ST_LERP: begin
				if (ph_q[0]) begin
					lv_q[lk_q] <= lsum[17:0];
				end
			end
			ST_ACCUM: begin
				noise_q <= noise_sel;
				acc_q <= acc_q + (ACC_W'(noise_sel) <<< (4'd15 - oct_q));
				cx_q <= {cx_q[30:0], 1'b0};
				cy_q <= {cy_q[30:0], 1'b0};
				cz_q <= {cz_q[30:0], 1'b0};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ax_q <= '0;
			ph_q <= '0;
			hs_q <= '0;
			lk_q <= '0;
			oct_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					ax_q <= '0;
					ph_q <= '0;
					hs_q <= '0;
					lk_q <= '0;
					oct_q <= '0;
					if (start && req_type) begin
						if (cfg.fractal_enable && oct_eff == 4'd0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_FADE;
						end
					end
				end
				ST_FADE: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						if (ax_q == 2'd2) begin
							ax_q <= '0;
							hs_q <= '0;
							state_q <= ST_HASH;
						end else begin
							ax_q <= ax_q + 2'd1;
						end
					end
				end
				ST_HASH: begin
					hs_q <= hs_q + 4'd1;
					if (hs_q == 4'd14) begin
						lk_q <= '0;
						ph_q <= '0;
						state_q <= ST_LERP;
					end
				end
				ST_LERP: begin
					ph_q <= {1'b0, ~ph_q[0]};
					if (ph_q[0]) begin
						if (lk_q == 3'd6) begin
							state_q <= ST_ACCUM;
						end else begin
							lk_q <= lk_q + 3'd1;
						end
					end
				end
				ST_ACCUM: begin
					oct_q <= oct_q + 4'd1;
					ph_q <= '0;
					if (cfg.fractal_enable && (oct_q + 4'd1) < oct_eff) begin
						state_q <= ST_FADE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### src/gradient_noise_fbm.sv
`timescale 1ns / 1ps
`default_nettype none
// A load item writes one hash table byte and gives no result. An evaluate item runs fade,
// table reads, interpolation and summing in turn for each octave, serialised by the one shared
// multiplier and the single table read port; raw noise is one octave.
// One item is in work at a time; a finished result waits in the output register.
// Reset clears control and configuration (dimensions 3, fractal off, four octaves);
// the hash table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// gradient_noise_fbm
// Improved gradient noise with optional fractal octave sum, stream interface.
// ----------------------------------------------------------------------------
module gradient_noise_fbm (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// table_index[7:0], table_value[15:8], coord_x[47:16], coord_y[79:48], coord_z[111:80]
	input  wire [111:0]  s_tdata,
	// req_type[0]
	input  wire          s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// noise_value[17:0], zero fill [23:18]
	output logic [23:0]  m_tdata,
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire [1:0]    cfg_index,
	input  wire [3:0]    cfg_data
);
	import gnf_pkg::*;

	cfg_t cfg_q;
	logic idle, res_valid, res_take, start;
	logic signed [17:0] res_value;
	logic m_tvalid_q;
	logic [17:0] value_q;

	assign cfg_ready = 1'b1;
	assign s_tready = idle;
	assign start = s_tvalid && s_tready;
	assign res_take = res_valid && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {6'd0, value_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dimensions <= 2'd3;
			cfg_q.fractal_enable <= 1'b0;
			cfg_q.octave_count <= 4'd4;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DIMENSIONS: cfg_q.dimensions <= cfg_data[1:0];
				REG_FRACTAL:    cfg_q.fractal_enable <= cfg_data[0];
				REG_OCTAVES:    cfg_q.octave_count <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			value_q <= res_value;
		end
	end

	gnf_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.start(start),
		.req_type(s_tuser),
		.table_index(s_tdata[7:0]),
		.table_value(s_tdata[15:8]),
		.coord_x(s_tdata[47:16]),
		.coord_y(s_tdata[79:48]),
		.coord_z(s_tdata[111:80]),
		.idle(idle),
		.res_valid(res_valid),
		.res_take(res_take),
		.res_value(res_value)
	);

endmodule
`default_nettype wire
